FILE: hdl/mrbv_pkg.sv
`timescale 1ns / 1ps

package mrbv_pkg;

	localparam int FRAC_BITS = 22;
	localparam int HALF_LSB  = 1 << (FRAC_BITS - 1);
	localparam int Q_ONE     = 1 << FRAC_BITS;
	localparam int COEF_W    = 24;
	localparam int STEP_W    = 23;
	localparam int CFG_W     = 23;
	localparam int CFG_IDX_W = 3;
	localparam int TERM_W    = 26;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_START   = 2'd1,
		OP_TICK    = 2'd2,
		OP_RELEASE = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE_COUNT  = 3'd0,
		CFG_GAIN_LEFT   = 3'd1,
		CFG_GAIN_RIGHT  = 3'd2,
		CFG_REL_STEP    = 3'd3,
		CFG_DELAY       = 3'd4,
		CFG_DURATION    = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_RELEASE,
		ST_SCALE,
		ST_GAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] re;
		logic signed [COEF_W-1:0] im;
		logic signed [COEF_W-1:0] rot_re;
		logic signed [COEF_W-1:0] rot_im;
		logic signed [COEF_W-1:0] level;
		logic        [STEP_W-1:0] step;
	} mode_t;

	typedef struct packed {
		logic shift;
		logic use_mode;
		logic acc_clear;
	} sweep_ctl_t;

	// round half up, then arithmetic shift by the fraction width
	function automatic logic signed [27:0] round_q(input logic signed [48:0] x);
		return 28'((x + 49'(HALF_LSB)) >>> FRAC_BITS);
	endfunction

	function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [27:0] x);
		logic signed [27:0] hi;
		logic signed [27:0] lo;
		hi = 28'((1 << (COEF_W - 1)) - 1);
		lo = ~hi;
		if (x > hi)
			return COEF_W'(hi);
		if (x < lo)
			return COEF_W'(lo);
		return COEF_W'(x);
	endfunction

	// level moves toward one by step times the remaining distance
	function automatic logic signed [COEF_W-1:0] env_next(
		input logic signed [COEF_W-1:0] level,
		input logic        [STEP_W-1:0] step
	);
		logic signed [24:0] diff;
		logic signed [48:0] prod;
		logic signed [27:0] sum;
		diff = 25'(Q_ONE) - 25'(level);
		prod = 49'(diff) * 49'($signed({1'b0, step}));
		sum  = round_q(prod) + 28'(level);
		return sat_coef(sum);
	endfunction

	// a*b + c*d, or a*b - c*d, rounded and saturated
	function automatic logic signed [COEF_W-1:0] cmul_part(
		input logic signed [COEF_W-1:0] a,
		input logic signed [COEF_W-1:0] b,
		input logic signed [COEF_W-1:0] c,
		input logic signed [COEF_W-1:0] d,
		input logic                     sub
	);
		logic signed [48:0] p;
		logic signed [48:0] q;
		logic signed [48:0] s;
		p = 49'(a) * 49'(b);
		q = 49'(c) * 49'(d);
		s = sub ? (p - q) : (p + q);
		return sat_coef(round_q(s));
	endfunction

endpackage

FILE: hdl/mrbv_cell.sv
`timescale 1ns / 1ps

module mrbv_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  logic           load,
	input  logic           clear,
	input  mrbv_pkg::mode_t shift_in,
	input  mrbv_pkg::mode_t load_in,
	output mrbv_pkg::mode_t held
);

	logic signed [mrbv_pkg::COEF_W-1:0] re_q;
	logic signed [mrbv_pkg::COEF_W-1:0] im_q;
	logic signed [mrbv_pkg::COEF_W-1:0] rot_re_q;
	logic signed [mrbv_pkg::COEF_W-1:0] rot_im_q;
	logic signed [mrbv_pkg::COEF_W-1:0] level_q;
	logic        [mrbv_pkg::STEP_W-1:0] step_q;

	// phasor, rotation and step: no reset, undefined until loaded
	always_ff @(posedge clk) begin
		if (shift) begin
			re_q     <= shift_in.re;
			im_q     <= shift_in.im;
			rot_re_q <= shift_in.rot_re;
			rot_im_q <= shift_in.rot_im;
			step_q   <= shift_in.step;
		end else if (load) begin
			re_q     <= load_in.re;
			im_q     <= load_in.im;
			rot_re_q <= load_in.rot_re;
			rot_im_q <= load_in.rot_im;
			step_q   <= load_in.step;
		end
	end

	// attack level is kept by a load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (clear) begin
			level_q <= '0;
		end else if (shift) begin
			level_q <= shift_in.level;
		end
	end

	always_comb begin
		held.re     = re_q;
		held.im     = im_q;
		held.rot_re = rot_re_q;
		held.rot_im = rot_im_q;
		held.level  = level_q;
		held.step   = step_q;
	end

endmodule

FILE: hdl/mrbv_mac.sv
`timescale 1ns / 1ps

module mrbv_mac #(
	parameter int ACC_W = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mrbv_pkg::sweep_ctl_t    ctl,
	input  mrbv_pkg::mode_t         head,
	output mrbv_pkg::mode_t         tail,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [mrbv_pkg::COEF_W-1:0] lvl_new;
	logic signed [mrbv_pkg::COEF_W-1:0] re_new;
	logic signed [mrbv_pkg::COEF_W-1:0] im_new;

	logic signed [mrbv_pkg::COEF_W-1:0] re_s1;
	logic signed [mrbv_pkg::COEF_W-1:0] lvl_s1;
	logic                               vld_s1;
	logic signed [mrbv_pkg::TERM_W-1:0] term_s2;
	logic                               vld_s2;
	logic signed [ACC_W-1:0]            acc_q;

	// envelope and phasor rotation of the mode at the head of the chain
	always_comb begin
		lvl_new = mrbv_pkg::env_next(head.level, head.step);
		re_new  = mrbv_pkg::cmul_part(head.re, head.rot_re, head.im, head.rot_im, 1'b1);
		im_new  = mrbv_pkg::cmul_part(head.re, head.rot_im, head.im, head.rot_re, 1'b0);
		tail    = head;
		if (ctl.use_mode) begin
			tail.re    = re_new;
			tail.im    = im_new;
			tail.level = lvl_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= ctl.shift && ctl.use_mode;
			vld_s2 <= vld_s1;
			if (ctl.acc_clear)
				acc_q <= '0;
			else if (vld_s2)
				acc_q <= acc_q + ACC_W'(term_s2);
		end
	end

	// term uses the old phasor and the new envelope
	always_ff @(posedge clk) begin
		re_s1   <= head.re;
		lvl_s1  <= lvl_new;
		term_s2 <= mrbv_pkg::TERM_W'(mrbv_pkg::round_q(49'(re_s1) * 49'(lvl_s1)));
	end

	assign acc = acc_q;

endmodule

FILE: hdl/modal_resonator_bank_voice.sv
// modal resonator bank voice: one mode per cell, the chain rotates once per sounding tick
// load, start and fast release are taken one per cycle while no tick is in progress; a silent tick
// goes straight to the output register, a sounding one sweeps the chain through one shared unit,
// applies the release gain if releasing, then the stereo gains; a voice ended by release emits
// silence; one transaction in flight: a tick holds the input off until its sample is registered
// async reset: voice off, envelopes and control and configuration registers zero, release gain one; no clearing pass
`timescale 1ns / 1ps

module modal_resonator_bank_voice #(
	parameter int MAX_MODES   = 64,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_write,
	input  logic [mrbv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mrbv_pkg::CFG_W-1:0]        cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        opcode,
	input  logic [5:0]                        mode_index,
	input  logic signed [23:0]                start_real,
	input  logic signed [23:0]                start_imag,
	input  logic signed [23:0]                rotation_real,
	input  logic signed [23:0]                rotation_imag,
	input  logic [22:0]                       attack_coef,
	// output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [SAMPLE_BITS-1:0]     left_sample,
	output logic signed [SAMPLE_BITS-1:0]     right_sample,
	output logic                              still_active
);

	// sum of rounded terms, each within +-2^24, over up to MAX_MODES modes
	localparam int ACC_W  = mrbv_pkg::TERM_W + $clog2(MAX_MODES);
	// wide product of the sum with a Q1.22 gain
	localparam int PRW    = ACC_W + 24;
	// sweep runs MAX_MODES shifts and then drains the term pipeline
	localparam int CW     = $clog2(MAX_MODES + 2);
	localparam int CMP_W  = (CW > 7) ? CW : 7;
	localparam logic [CW-1:0] SWEEP_LAST = CW'(MAX_MODES + 1);
	localparam logic signed [PRW-1:0] SAT_HI = PRW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [PRW-1:0] SAT_LO = ~SAT_HI;

	mrbv_pkg::state_t state_q, state_d;

	// configuration registers
	logic [6:0]  mode_count_q;
	logic [22:0] gain_left_q;
	logic [22:0] gain_right_q;
	logic [22:0] release_step_q;
	logic [19:0] delay_samples_q;
	logic [21:0] duration_q;

	// voice state
	logic [19:0]        delay_left_q;
	logic [21:0]        samples_left_q;
	logic signed [23:0] release_gain_q;
	logic               releasing_q;
	logic               voice_on_q;

	logic [CW-1:0]      cnt_q;
	logic signed [ACC_W-1:0] sum_q;
	logic signed [SAMPLE_BITS-1:0] res_left_q;
	logic signed [SAMPLE_BITS-1:0] res_right_q;
	logic               res_active_q;
	logic               out_valid_q;
	logic signed [SAMPLE_BITS-1:0] left_q;
	logic signed [SAMPLE_BITS-1:0] right_q;
	logic               active_q;

	logic               accept;
	logic               emit_fire;
	logic               rel_on;
	logic               gain_nonpos;
	logic signed [24:0] gain_next;
	mrbv_pkg::sweep_ctl_t ctl;

	// chain of mode cells
	mrbv_pkg::mode_t    cell_q [MAX_MODES];
	mrbv_pkg::mode_t    tail;
	mrbv_pkg::mode_t    load_in;
	logic signed [ACC_W-1:0] acc;

	logic signed [PRW-1:0] prod_rel;
	logic signed [PRW-1:0] scaled;
	logic signed [PRW-1:0] prod_l;
	logic signed [PRW-1:0] prod_r;
	logic signed [PRW-1:0] rnd_l;
	logic signed [PRW-1:0] rnd_r;
	logic signed [PRW-1:0] sat_l;
	logic signed [PRW-1:0] sat_r;

	assign accept = in_valid && in_ready;

	// a load writes the cell whose index matches; indexes past the bank match none
	always_comb begin
		load_in.re     = start_real;
		load_in.im     = start_imag;
		load_in.rot_re = rotation_real;
		load_in.rot_im = rotation_imag;
		load_in.level  = '0;
		load_in.step   = attack_coef;
	end

	for (genvar i = 0; i < MAX_MODES; i++) begin : g_cell
		mrbv_pkg::mode_t nbr;
		if (i == MAX_MODES - 1) begin : g_tail
			assign nbr = tail;
		end else begin : g_mid
			assign nbr = cell_q[i+1];
		end
		mrbv_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (ctl.shift),
			.load     (accept && (opcode == mrbv_pkg::OP_LOAD) && (32'(mode_index) == i)),
			.clear    (accept && (opcode == mrbv_pkg::OP_START)),
			.shift_in (nbr),
			.load_in  (load_in),
			.held     (cell_q[i])
		);
	end

	// shared unit: cell 0 goes in, its updated mode comes back at the far end
	mrbv_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.head   (cell_q[0]),
		.tail   (tail),
		.acc    (acc)
	);

	// fast release: gain drops by the step, the voice ends when it reaches zero
	assign rel_on      = releasing_q && (release_step_q != '0);
	assign gain_next   = 25'(release_gain_q) - $signed({2'b00, release_step_q});
	assign gain_nonpos = gain_next[24] || (gain_next == '0);

	// output arithmetic
	always_comb begin
		prod_rel = PRW'(sum_q) * PRW'(release_gain_q);
		scaled   = (prod_rel + PRW'(mrbv_pkg::HALF_LSB)) >>> mrbv_pkg::FRAC_BITS;
		prod_l   = PRW'(sum_q) * PRW'($signed({1'b0, gain_left_q}));
		prod_r   = PRW'(sum_q) * PRW'($signed({1'b0, gain_right_q}));
		rnd_l    = (prod_l + PRW'(mrbv_pkg::HALF_LSB)) >>> mrbv_pkg::FRAC_BITS;
		rnd_r    = (prod_r + PRW'(mrbv_pkg::HALF_LSB)) >>> mrbv_pkg::FRAC_BITS;
		sat_l    = (rnd_l > SAT_HI) ? SAT_HI : ((rnd_l < SAT_LO) ? SAT_LO : rnd_l);
		sat_r    = (rnd_r > SAT_HI) ? SAT_HI : ((rnd_r < SAT_LO) ? SAT_LO : rnd_r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mrbv_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state, handshake and sweep control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		emit_fire = 1'b0;
		ctl       = '0;
		unique case (state_q)
			mrbv_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (opcode == mrbv_pkg::OP_TICK)) begin
					if (voice_on_q && (delay_left_q == '0)) begin
						state_d       = mrbv_pkg::ST_SWEEP;
						ctl.acc_clear = 1'b1;
					end else begin
						state_d = mrbv_pkg::ST_EMIT;
					end
				end
			end
			mrbv_pkg::ST_SWEEP: begin
				ctl.shift    = 32'(cnt_q) < MAX_MODES;
				ctl.use_mode = ctl.shift && (CMP_W'(cnt_q) < CMP_W'(mode_count_q));
				if (cnt_q == SWEEP_LAST)
					state_d = mrbv_pkg::ST_RELEASE;
			end
			mrbv_pkg::ST_RELEASE: begin
				if (rel_on)
					state_d = gain_nonpos ? mrbv_pkg::ST_EMIT : mrbv_pkg::ST_SCALE;
				else
					state_d = mrbv_pkg::ST_GAIN;
			end
			mrbv_pkg::ST_SCALE: begin
				state_d = mrbv_pkg::ST_GAIN;
			end
			mrbv_pkg::ST_GAIN: begin
				state_d = mrbv_pkg::ST_EMIT;
			end
			mrbv_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					emit_fire = 1'b1;
					state_d   = mrbv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mrbv_pkg::ST_IDLE;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_count_q    <= '0;
			gain_left_q     <= '0;
			gain_right_q    <= '0;
			release_step_q  <= '0;
			delay_samples_q <= '0;
			duration_q      <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mrbv_pkg::CFG_MODE_COUNT: mode_count_q    <= cfg_data[6:0];
				mrbv_pkg::CFG_GAIN_LEFT:  gain_left_q     <= cfg_data[22:0];
				mrbv_pkg::CFG_GAIN_RIGHT: gain_right_q    <= cfg_data[22:0];
				mrbv_pkg::CFG_REL_STEP:   release_step_q  <= cfg_data[22:0];
				mrbv_pkg::CFG_DELAY:      delay_samples_q <= cfg_data[19:0];
				mrbv_pkg::CFG_DURATION:   duration_q      <= cfg_data[21:0];
				default: ;
			endcase
		end
	end

	// voice control state, sweep counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_left_q   <= '0;
			samples_left_q <= '0;
			release_gain_q <= 24'(mrbv_pkg::Q_ONE);
			releasing_q    <= 1'b0;
			voice_on_q     <= 1'b0;
			cnt_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (accept) begin
				case (opcode)
					mrbv_pkg::OP_START: begin
						delay_left_q   <= delay_samples_q;
						samples_left_q <= duration_q;
						release_gain_q <= 24'(mrbv_pkg::Q_ONE);
						releasing_q    <= 1'b0;
						voice_on_q     <= duration_q != '0;
					end
					mrbv_pkg::OP_RELEASE: begin
						if (voice_on_q)
							releasing_q <= 1'b1;
					end
					mrbv_pkg::OP_TICK: begin
						// silent delay tick: modes hold still
						if (voice_on_q && (delay_left_q != '0))
							delay_left_q <= delay_left_q - 20'd1;
					end
					default: ;
				endcase
			end

			if (state_q == mrbv_pkg::ST_SWEEP)
				cnt_q <= cnt_q + CW'(1);
			else
				cnt_q <= '0;

			if ((state_q == mrbv_pkg::ST_RELEASE) && rel_on) begin
				if (gain_nonpos)
					voice_on_q <= 1'b0;
				else
					release_gain_q <= gain_next[23:0];
			end

			if (state_q == mrbv_pkg::ST_GAIN) begin
				samples_left_q <= samples_left_q - 22'd1;
				voice_on_q     <= samples_left_q != 22'd1;
			end

			if (emit_fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept && (opcode == mrbv_pkg::OP_TICK)) begin
			// voice off gives silence and inactive, delay gives silence and active
			res_left_q   <= '0;
			res_right_q  <= '0;
			res_active_q <= voice_on_q && (delay_left_q != '0);
		end
		if (state_q == mrbv_pkg::ST_RELEASE) begin
			sum_q <= acc;
			if (rel_on && gain_nonpos) begin
				res_left_q   <= '0;
				res_right_q  <= '0;
				res_active_q <= 1'b0;
			end
		end
		if (state_q == mrbv_pkg::ST_SCALE)
			sum_q <= ACC_W'(scaled);
		if (state_q == mrbv_pkg::ST_GAIN) begin
			res_left_q   <= SAMPLE_BITS'(sat_l);
			res_right_q  <= SAMPLE_BITS'(sat_r);
			res_active_q <= samples_left_q != 22'd1;
		end
		if (emit_fire) begin
			left_q   <= res_left_q;
			right_q  <= res_right_q;
			active_q <= res_active_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign left_sample  = left_q;
	assign right_sample = right_q;
	assign still_active = active_q;

endmodule

FILE: test/tb_modal_resonator_bank_voice.sv
`timescale 1ns / 1ps

module tb_modal_resonator_bank_voice;

	localparam int NUM_SLOTS    = 64;
	localparam int SETTLE_TICKS = NUM_SLOTS + 16;   // longest tick plus margin
	localparam logic signed [23:0] COEF_MAX = 24'sh7fffff;
	localparam logic signed [23:0] COEF_MIN = 24'sh800000;

	// one input transaction, field by field
	typedef struct {
		mrbv_pkg::opcode_t  op;
		logic [5:0]         slot;
		logic signed [23:0] s_re;
		logic signed [23:0] s_im;
		logic signed [23:0] r_re;
		logic signed [23:0] r_im;
		logic [22:0]        coef;
	} voice_txn_t;

	// one output transaction
	typedef struct {
		logic signed [23:0] left;
		logic signed [23:0] right;
		logic               active;
	} stereo_sample_t;

	typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

	// voice predictor plus queue of expected stereo samples
	class voice_scoreboard;
		logic [6:0]         mode_limit;
		logic [22:0]        gain_l;
		logic [22:0]        gain_r;
		logic [22:0]        rel_step;
		logic [19:0]        delay_cfg;
		logic [21:0]        length_cfg;
		logic signed [23:0] ph_re[NUM_SLOTS];
		logic signed [23:0] ph_im[NUM_SLOTS];
		logic signed [23:0] rot_re[NUM_SLOTS];
		logic signed [23:0] rot_im[NUM_SLOTS];
		logic signed [23:0] env_level[NUM_SLOTS];
		logic [22:0]        env_coef[NUM_SLOTS];
		logic [19:0]        delay_cnt;
		logic [21:0]        sound_cnt;
		longint             rel_gain;
		bit                 releasing;
		bit                 voice_live;
		stereo_sample_t     expected_samples[$];
		int                 mismatches;

		function new();
			mode_limit = '0;
			gain_l     = '0;
			gain_r     = '0;
			rel_step   = '0;
			delay_cfg  = '0;
			length_cfg = '0;
			for (int k = 0; k < NUM_SLOTS; k++) begin
				ph_re[k]     = '0;
				ph_im[k]     = '0;
				rot_re[k]    = '0;
				rot_im[k]    = '0;
				env_level[k] = '0;
				env_coef[k]  = '0;
			end
			delay_cnt   = '0;
			sound_cnt   = '0;
			rel_gain    = longint'(mrbv_pkg::Q_ONE);
			releasing   = 1'b0;
			voice_live  = 1'b0;
			mismatches  = 0;
		endfunction

		// round half up, then drop the fraction
		function longint q_round(longint x);
			return (x + longint'(mrbv_pkg::HALF_LSB)) >>> mrbv_pkg::FRAC_BITS;
		endfunction

		function longint clip_signed(longint x, int bits);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (bits - 1)) - 1;
			lo = -hi - 1;
			if (x > hi)
				return hi;
			if (x < lo)
				return lo;
			return x;
		endfunction

		function void write_reg(mrbv_pkg::cfg_reg_t idx, logic [22:0] data);
			case (idx)
			mrbv_pkg::CFG_MODE_COUNT: mode_limit = data[6:0];
			mrbv_pkg::CFG_GAIN_LEFT:  gain_l     = data;
			mrbv_pkg::CFG_GAIN_RIGHT: gain_r     = data;
			mrbv_pkg::CFG_REL_STEP:   rel_step   = data;
			mrbv_pkg::CFG_DELAY:      delay_cfg  = data[19:0];
			mrbv_pkg::CFG_DURATION:   length_cfg = data[21:0];
			default: ;
			endcase
		endfunction

		function void accept_command(voice_txn_t t);
			stereo_sample_t e;
			longint re;
			longint im;
			longint rr;
			longint ri;
			longint lvl;
			longint acc;
			int n;
			bit cut;
			e.left   = '0;
			e.right  = '0;
			e.active = 1'b0;
			case (t.op)
			mrbv_pkg::OP_LOAD: begin
				// envelope level is kept as it is
				ph_re[t.slot]    = t.s_re;
				ph_im[t.slot]    = t.s_im;
				rot_re[t.slot]   = t.r_re;
				rot_im[t.slot]   = t.r_im;
				env_coef[t.slot] = t.coef;
			end
			mrbv_pkg::OP_START: begin
				for (int k = 0; k < NUM_SLOTS; k++)
					env_level[k] = '0;
				delay_cnt  = delay_cfg;
				sound_cnt  = length_cfg;
				rel_gain   = longint'(mrbv_pkg::Q_ONE);
				releasing  = 1'b0;
				voice_live = (length_cfg != 0);
			end
			mrbv_pkg::OP_RELEASE: begin
				if (voice_live)
					releasing = 1'b1;
			end
			mrbv_pkg::OP_TICK: begin
				if (voice_live) begin
					if (delay_cnt != 0) begin
						delay_cnt--;
						e.active = 1'b1;
					end else begin
						n   = (mode_limit > NUM_SLOTS) ? NUM_SLOTS : int'(mode_limit);
						acc = 0;
						for (int k = 0; k < n; k++) begin
							re  = longint'(ph_re[k]);
							im  = longint'(ph_im[k]);
							rr  = longint'(rot_re[k]);
							ri  = longint'(rot_im[k]);
							lvl = longint'(env_level[k]);
							lvl = clip_signed(lvl + q_round((longint'(mrbv_pkg::Q_ONE) - lvl) *
								longint'(env_coef[k])), 24);
							env_level[k] = 24'(lvl);
							acc += q_round(re * lvl);
							ph_re[k] = 24'(clip_signed(q_round(re * rr - im * ri), 24));
							ph_im[k] = 24'(clip_signed(q_round(re * ri + im * rr), 24));
						end
						cut = 1'b0;
						if (releasing && rel_step != 0) begin
							rel_gain -= longint'(rel_step);
							if (rel_gain <= 0) begin
								voice_live = 1'b0;
								cut = 1'b1;
							end else begin
								acc = q_round(acc * rel_gain);
							end
						end
						if (!cut) begin
							e.left  = 24'(clip_signed(q_round(acc * longint'(gain_l)), 24));
							e.right = 24'(clip_signed(q_round(acc * longint'(gain_r)), 24));
							sound_cnt--;
							if (sound_cnt == 0)
								voice_live = 1'b0;
							e.active = voice_live;
						end
					end
				end
				expected_samples.push_back(e);
			end
			default: ;
			endcase
		endfunction

		task report(string msg);
			$display("ERROR %0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_sample(logic signed [23:0] l, logic signed [23:0] r, logic act);
			stereo_sample_t e;
			if (expected_samples.size() == 0) begin
				report("sample arrived with none pending");
			end else begin
				e = expected_samples.pop_front();
				if (l !== e.left)
					report($sformatf("left_sample %0d, want %0d", l, e.left));
				if (r !== e.right)
					report($sformatf("right_sample %0d, want %0d", r, e.right));
				if (act !== e.active)
					report($sformatf("still_active %0b, want %0b", act, e.active));
			end
		endtask
	endclass

	// dut inputs, all known from time zero
	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               cfg_write     = 1'b0;
	logic [2:0]         cfg_index     = '0;
	logic [22:0]        cfg_data      = '0;
	logic               in_valid      = 1'b0;
	logic               in_ready;
	logic [1:0]         opcode        = '0;
	logic [5:0]         mode_index    = '0;
	logic signed [23:0] start_real    = '0;
	logic signed [23:0] start_imag    = '0;
	logic signed [23:0] rotation_real = '0;
	logic signed [23:0] rotation_imag = '0;
	logic [22:0]        attack_coef   = '0;
	logic               out_valid;
	logic               out_ready     = 1'b0;
	logic signed [23:0] left_sample;
	logic signed [23:0] right_sample;
	logic               still_active;

	voice_scoreboard sb = new();
	int burst_left   = 0;    // transactions left in the current sender burst
	int slots_ready  = 0;    // slots 0 .. slots_ready-1 hold loaded data
	int samples_seen = 0;

	modal_resonator_bank_voice u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.mode_index    (mode_index),
		.start_real    (start_real),
		.start_imag    (start_imag),
		.rotation_real (rotation_real),
		.rotation_imag (rotation_imag),
		.attack_coef   (attack_coef),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.left_sample   (left_sample),
		.right_sample  (right_sample),
		.still_active  (still_active)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// coefficient mix: rails, zero, full random and smaller magnitudes
	function automatic logic signed [23:0] rand_coef();
		case ($urandom_range(0, 7))
		0: return COEF_MAX;
		1: return COEF_MIN;
		2: return '0;
		3, 4: return 24'($urandom);
		default: return $signed(24'($urandom)) >>> $urandom_range(1, 6);
		endcase
	endfunction

	// attack coefficient: mostly realistic, sometimes zero, one or the full 23-bit range
	function automatic logic [22:0] rand_attack();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return 23'(mrbv_pkg::Q_ONE);
		2: return 23'($urandom);
		default: return 23'($urandom_range(1000, 600000));
		endcase
	endfunction

	function automatic voice_txn_t random_txn();
		voice_txn_t t;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			t.op = mrbv_pkg::OP_LOAD;
		else if (pick < 20)
			t.op = mrbv_pkg::OP_START;
		else if (pick < 26)
			t.op = mrbv_pkg::OP_RELEASE;
		else
			t.op = mrbv_pkg::OP_TICK;
		// unused fields still carry random bits
		t.slot = 6'($urandom);
		t.s_re = rand_coef();
		t.s_im = rand_coef();
		t.r_re = rand_coef();
		t.r_im = rand_coef();
		t.coef = rand_attack();
		return t;
	endfunction

	function automatic voice_txn_t mk(mrbv_pkg::opcode_t op, logic [5:0] slot,
		logic signed [23:0] a, logic signed [23:0] b,
		logic signed [23:0] c, logic signed [23:0] d, logic [22:0] coef);
		voice_txn_t t;
		t.op   = op;
		t.slot = slot;
		t.s_re = a;
		t.s_im = b;
		t.r_re = c;
		t.r_im = d;
		t.coef = coef;
		return t;
	endfunction

	// drive one input transaction; valid stays high afterwards unless a gap follows
	task automatic send_txn(input voice_txn_t t);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
			// every so often a long burst with no idling at all
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
				: $urandom_range(1, 20);
		end
		burst_left--;
		in_valid      <= 1'b1;
		opcode        <= t.op;
		mode_index    <= t.slot;
		start_real    <= t.s_re;
		start_imag    <= t.s_im;
		rotation_real <= t.r_re;
		rotation_imag <= t.r_im;
		attack_coef   <= t.coef;
		do
			@(posedge clk);
		while (!in_ready);
		sb.accept_command(t);
	endtask

	// stop offering, collect every pending sample, then let a full tick pass
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_reg(mrbv_pkg::cfg_reg_t idx, logic [22:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// registers only change while the block is idle
	task automatic configure(logic [22:0] modes, logic [22:0] gl, logic [22:0] gr,
		logic [22:0] step, logic [22:0] dly, logic [22:0] dur);
		settle();
		write_reg(mrbv_pkg::CFG_MODE_COUNT, modes);
		write_reg(mrbv_pkg::CFG_GAIN_LEFT, gl);
		write_reg(mrbv_pkg::CFG_GAIN_RIGHT, gr);
		write_reg(mrbv_pkg::CFG_REL_STEP, step);
		write_reg(mrbv_pkg::CFG_DELAY, dly);
		write_reg(mrbv_pkg::CFG_DURATION, dur);
		cfg_write <= 1'b0;
	endtask

	// every slot a tick will read gets loaded first
	task automatic ensure_loaded(int count);
		voice_txn_t t;
		while (slots_ready < count) begin
			t      = random_txn();
			t.op   = mrbv_pkg::OP_LOAD;
			t.slot = 6'(slots_ready);
			send_txn(t);
			slots_ready++;
		end
	endtask

	task automatic run_phase(logic [22:0] modes, logic [22:0] gl, logic [22:0] gr,
		logic [22:0] step, logic [22:0] dly, logic [22:0] dur, int count);
		configure(modes, gl, gr, step, dly, dur);
		ensure_loaded((modes > NUM_SLOTS) ? NUM_SLOTS : int'(modes));
		repeat (count) send_txn(random_txn());
	endtask

	// output side: check each sample, stall on a pattern of its own
	initial begin : sample_sink
		int          hold_left;
		int          holds_done;
		int          rx_left;
		int unsigned cyc;
		rx_pattern_t rx_mode;
		logic        rdy;
		hold_left  = 0;
		holds_done = 0;
		rx_left    = 0;
		cyc        = 0;
		rx_mode    = RX_ALWAYS;
		rdy        = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (arst_n && out_valid && out_ready) begin
				sb.check_sample(left_sample, right_sample, still_active);
				samples_seen++;
				// long hold-off twice in the run, so the block backs up into its input
				if (holds_done < 2 && samples_seen == 150 + 450 * holds_done) begin
					hold_left = 400;
					holds_done++;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = rx_pattern_t'($urandom_range(0, 3));
					rx_left = $urandom_range(20, 250);
				end
				rx_left--;
				case (rx_mode)
				RX_ALWAYS: rdy = 1'b1;
				RX_COIN:   rdy = 1'($urandom_range(0, 1));
				RX_SPARSE: rdy = ($urandom_range(0, 5) == 0);
				default:   rdy = ((cyc % 4) != 3);
				endcase
			end
			out_ready <= rdy;
		end
	end

	// stimulus: reset, directed checks, then phases of random transactions
	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: four modes, left gain one, right gain zero, no release step
		configure(23'd4, 23'(mrbv_pkg::Q_ONE), 23'd0, 23'd0, 23'd2, 23'd6);
		// tick and fast release while the voice is off
		send_txn(mk(mrbv_pkg::OP_TICK, 6'd63, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN,
			23'h7fffff));
		send_txn(mk(mrbv_pkg::OP_RELEASE, 6'd0, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX,
			23'd0));
		// rails on every coefficient, attack from zero up to the 23-bit maximum
		send_txn(mk(mrbv_pkg::OP_LOAD, 6'd0, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN,
			23'(mrbv_pkg::Q_ONE)));
		send_txn(mk(mrbv_pkg::OP_LOAD, 6'd1, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, 23'd0));
		send_txn(mk(mrbv_pkg::OP_LOAD, 6'd2, 24'sh2d4130, -24'sh1f0a3c, 24'sh3e8000,
			24'sh0c8f00, 23'h7fffff));
		send_txn(mk(mrbv_pkg::OP_LOAD, 6'd3, 24'sh100000, 24'sh000000, 24'sh3f0000,
			-24'sh0a0000, 23'h155555));
		send_txn(mk(mrbv_pkg::OP_START, 6'd0, '0, '0, '0, '0, '0));
		// two silent delay ticks
		repeat (2) send_txn(mk(mrbv_pkg::OP_TICK, 6'd0, '0, '0, '0, '0, '0));
		// release with a zero step leaves the sum alone
		send_txn(mk(mrbv_pkg::OP_RELEASE, 6'd0, '0, '0, '0, '0, '0));
		// six sounding ticks, the last one ends the voice, then one more while off
		repeat (7) send_txn(mk(mrbv_pkg::OP_TICK, 6'd0, '0, '0, '0, '0, '0));
		// restart during the delay, and a load while armed
		send_txn(mk(mrbv_pkg::OP_START, 6'd0, '0, '0, '0, '0, '0));
		send_txn(mk(mrbv_pkg::OP_TICK, 6'd0, '0, '0, '0, '0, '0));
		send_txn(mk(mrbv_pkg::OP_START, 6'd0, '0, '0, '0, '0, '0));
		send_txn(mk(mrbv_pkg::OP_LOAD, 6'd2, -24'sh300000, 24'sh200000, 24'sh3fff00,
			24'sh001000, 23'd200000));
		repeat (3) send_txn(mk(mrbv_pkg::OP_TICK, 6'd0, '0, '0, '0, '0, '0));
		slots_ready = 4;

		// all modes, full gains, a release step of one cuts the voice at once
		run_phase(23'd64, 23'(mrbv_pkg::Q_ONE), 23'(mrbv_pkg::Q_ONE), 23'(mrbv_pkg::Q_ONE),
			23'd0, 23'd20, 160);
		// no modes summed, one-sample voices
		run_phase(23'd0, 23'($urandom_range(0, mrbv_pkg::Q_ONE)),
			23'($urandom_range(0, mrbv_pkg::Q_ONE)), 23'd0, 23'd1, 23'd1, 120);
		// mode count above the bank size, longest duration, smallest release step
		run_phase(23'd100, 23'(mrbv_pkg::Q_ONE), 23'd1, 23'd1, 23'd0, 23'd4194303, 150);
		// longest delay: the voice never gets past its silent part
		run_phase(23'd1, 23'd0, 23'(mrbv_pkg::Q_ONE), 23'd350000, 23'd1048575, 23'd12, 60);
		// zero duration: a start never arms the voice
		run_phase(23'd8, 23'($urandom_range(0, mrbv_pkg::Q_ONE)),
			23'($urandom_range(0, mrbv_pkg::Q_ONE)),
			23'($urandom_range(0, mrbv_pkg::Q_ONE)), 23'd0, 23'd0, 60);
		// random settings with short voices
		repeat (4)
			run_phase(23'($urandom_range(1, 64)), 23'($urandom_range(0, mrbv_pkg::Q_ONE)),
				23'($urandom_range(0, mrbv_pkg::Q_ONE)),
				($urandom_range(0, 2) == 0) ? 23'd0 : 23'($urandom_range(1, 400000)),
				23'($urandom_range(0, 3)), 23'($urandom_range(1, 30)), 120);

		settle();
		if (sb.expected_samples.size() != 0)
			sb.report($sformatf("%0d samples never arrived", sb.expected_samples.size()));
		if (sb.mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#15_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: files.f
hdl/mrbv_pkg.sv
hdl/mrbv_cell.sv
hdl/mrbv_mac.sv
hdl/modal_resonator_bank_voice.sv
test/tb_modal_resonator_bank_voice.sv
